// ===== hdl/ipv4fk_pkg.sv =====
package ipv4fk_pkg;

  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  PROTO_TCP         = 8'd6;
  localparam logic [7:0]  PROTO_UDP         = 8'd17;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

  localparam logic [16:0] MIN_PACKET_BYTES  = 17'd20;
  localparam logic [15:0] TCP_HDR_BYTES     = 16'd20;
  localparam logic [15:0] ICMP_HDR_BYTES    = 16'd16;
  localparam logic [15:0] UDP_HDR_BYTES     = 16'd8;

  localparam logic [15:0] BYTE_INDEX_MAX    = 16'hFFFF;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  proto_number;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_len;
  } flow_key_t;

endpackage

// ===== hdl/ipv4fk_byte_if.sv =====
interface ipv4fk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/ipv4fk_key_if.sv =====
interface ipv4fk_key_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  proto_number;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] payload_len;

  modport source (
    output valid, output accepted, output proto_number, output source_address,
    output dest_address, output source_port, output dest_port, output payload_len,
    input ready
  );
  modport sink (
    input valid, input accepted, input proto_number, input source_address,
    input dest_address, input source_port, input dest_port, input payload_len,
    output ready
  );
endinterface

// ===== hdl/ipv4_flow_key_extractor_core.sv =====
// IPv4 flow key extractor. Packet bytes enter on pkt, one item per byte in wire
// order, last_byte set on the final one; each packet yields exactly one key item
// on key: accepted, protocol, addresses, ports (ICMP echo id as source port) and
// payload length, or an all-zero key with accepted low for a refused packet.
// The block takes one byte per cycle unless stalled: a byte register feeds the
// capture/result logic, and the key is registered as the final byte leaves the
// byte register. pkt.ready drops only while a final byte waits behind a key that has not been taken.
module ipv4_flow_key_extractor_core
  import ipv4fk_pkg::*;
(
  input logic         clk,
  input logic         rst,
  ipv4fk_byte_if.sink pkt,
  ipv4fk_key_if.source key
);

  // byte register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // packet state
  logic [15:0] byte_index;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [7:0]  proto_reg;
  logic [31:0] src_addr_reg;
  logic [31:0] dst_addr_reg;
  logic [15:0] port_a_reg;
  logic [15:0] port_b_reg;
  logic [15:0] udp_length_reg;
  logic [7:0]  icmp_type_reg;

  logic [15:0] byte_index_next;
  logic [3:0]  header_words_next;
  logic [15:0] total_length_next;
  logic [7:0]  proto_next;
  logic [31:0] src_addr_next;
  logic [31:0] dst_addr_next;
  logic [15:0] port_a_next;
  logic [15:0] port_b_next;
  logic [15:0] udp_length_next;
  logic [7:0]  icmp_type_next;

  logic [15:0] hdr_off;
  logic [16:0] count;
  logic [16:0] need;
  logic [15:0] sub_a;
  logic [15:0] sub_b;
  logic [15:0] plen;
  logic        ok;
  flow_key_t   key_next;
  flow_key_t   key_r;
  logic        key_valid;

  assign s1_fire   = s1_valid && (!s1_last || !key_valid || key.ready);
  assign pkt.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
    if (pkt.ready && pkt.valid) begin
      s1_byte <= pkt.data_byte;
      s1_last <= pkt.last_byte;
    end
  end

  always_comb begin
    header_words_next = (byte_index == 16'd0) ? s1_byte[3:0] : header_words;
    // transport offset follows the IHL nibble arriving on byte 0 itself
    hdr_off = {10'd0, header_words_next, 2'b00};

    total_length_next = (byte_index == 16'd2 || byte_index == 16'd3) ?
                        {total_length[7:0], s1_byte} : total_length;
    proto_next = (byte_index == 16'd9) ? s1_byte : proto_reg;
    src_addr_next = (byte_index >= 16'd12 && byte_index <= 16'd15) ?
                    {src_addr_reg[23:0], s1_byte} : src_addr_reg;
    dst_addr_next = (byte_index >= 16'd16 && byte_index <= 16'd19) ?
                    {dst_addr_reg[23:0], s1_byte} : dst_addr_reg;

    icmp_type_next = (byte_index == hdr_off) ? s1_byte : icmp_type_reg;
    port_a_next = (byte_index == hdr_off || byte_index == hdr_off + 16'd1) ?
                  {port_a_reg[7:0], s1_byte} : port_a_reg;
    port_b_next = (byte_index == hdr_off + 16'd2 || byte_index == hdr_off + 16'd3) ?
                  {port_b_reg[7:0], s1_byte} : port_b_reg;
    udp_length_next = (byte_index == hdr_off + 16'd4 || byte_index == hdr_off + 16'd5) ?
                      {udp_length_reg[7:0], s1_byte} : udp_length_reg;

    byte_index_next = (byte_index != BYTE_INDEX_MAX) ? byte_index + 16'd1 : byte_index;
  end

  // final-byte evaluation
  always_comb begin
    count    = {1'b0, byte_index} + 17'd1;
    ok       = (count >= MIN_PACKET_BYTES);
    need     = 17'd0;
    sub_a    = total_length_next;
    sub_b    = hdr_off + TCP_HDR_BYTES;
    key_next = '0;
    case (proto_next)
      PROTO_TCP: begin
        need = {1'b0, hdr_off} + 17'd4;
        key_next.source_port = port_a_next;
        key_next.dest_port   = port_b_next;
      end
      PROTO_UDP: begin
        need  = {1'b0, hdr_off} + 17'd6;
        sub_a = udp_length_next;
        sub_b = UDP_HDR_BYTES;
        key_next.source_port = port_a_next;
        key_next.dest_port   = port_b_next;
      end
      PROTO_ICMP: begin
        need  = {1'b0, hdr_off} + 17'd6;
        sub_b = hdr_off + ICMP_HDR_BYTES;
        if (icmp_type_next != ICMP_ECHO_REQUEST) begin
          ok = 1'b0;
        end
        key_next.source_port = udp_length_next;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (count < need) begin
      ok = 1'b0;
    end
    plen = (sub_a > sub_b) ? sub_a - sub_b : 16'd0;
    key_next.accepted       = 1'b1;
    key_next.proto_number   = proto_next;
    key_next.source_address = src_addr_next;
    key_next.dest_address   = dst_addr_next;
    key_next.payload_len    = plen;
    if (!ok) begin
      key_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      byte_index     <= '0;
      header_words   <= '0;
      total_length   <= '0;
      proto_reg      <= '0;
      src_addr_reg   <= '0;
      dst_addr_reg   <= '0;
      port_a_reg     <= '0;
      port_b_reg     <= '0;
      udp_length_reg <= '0;
      icmp_type_reg  <= '0;
    end else if (s1_fire) begin
      byte_index     <= byte_index_next;
      header_words   <= header_words_next;
      total_length   <= total_length_next;
      proto_reg      <= proto_next;
      src_addr_reg   <= src_addr_next;
      dst_addr_reg   <= dst_addr_next;
      port_a_reg     <= port_a_next;
      port_b_reg     <= port_b_next;
      udp_length_reg <= udp_length_next;
      icmp_type_reg  <= icmp_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      key_valid <= 1'b1;
    end else if (key.ready) begin
      key_valid <= 1'b0;
    end
    if (s1_fire && s1_last) begin
      key_r <= key_next;
    end
  end

  assign key.valid          = key_valid;
  assign key.accepted       = key_r.accepted;
  assign key.proto_number   = key_r.proto_number;
  assign key.source_address = key_r.source_address;
  assign key.dest_address   = key_r.dest_address;
  assign key.source_port    = key_r.source_port;
  assign key.dest_port      = key_r.dest_port;
  assign key.payload_len    = key_r.payload_len;

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_r.accepted |-> key_r.proto_number == 8'd0 &&
      key_r.source_address == 32'd0 && key_r.source_port == 16'd0 &&
      key_r.payload_len == 16'd0)
    else $error("refused key carries nonzero fields");

  a_accepted_proto: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_r.accepted |-> key_r.proto_number == PROTO_TCP ||
      key_r.proto_number == PROTO_UDP || key_r.proto_number == PROTO_ICMP)
    else $error("accepted key with unsupported protocol");

  a_icmp_dport: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_r.accepted && key_r.proto_number == PROTO_ICMP |->
      key_r.dest_port == 16'd0)
    else $error("ICMP key with nonzero destination port");

  a_state_clear: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> byte_index == 16'd0 && key_valid)
    else $error("packet state not cleared or key missing after final byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key.ready |-> !(s1_fire && s1_last))
    else $error("pending key overwritten");

endmodule

// ===== bench/tb.sv =====
module tb
  import ipv4fk_pkg::*;
();

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;
  localparam int TOTAL_BYTES = 1750;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain;
  } pkt_item_t;

  logic clk = 1'b0;
  logic rst;

  ipv4fk_byte_if pkt_if();
  ipv4fk_key_if  key_if();

  ipv4_flow_key_extractor_core dut (
    .clk(clk),
    .rst(rst),
    .pkt(pkt_if),
    .key(key_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pkt_item_t byte_q[$];
  flow_key_t key_exp[$];
  int        bytes_total;
  int        bytes_taken = 0;
  int        keys_seen = 0;
  int        errors = 0;
  int        cyc = 0;

  // predictor state, cleared after every final byte
  logic [15:0] pos = '0;
  logic [3:0]  ihl = '0;
  logic [15:0] tot_len = '0;
  logic [7:0]  proto = '0;
  logic [31:0] saddr = '0;
  logic [31:0] daddr = '0;
  logic [15:0] port_a = '0;
  logic [15:0] port_b = '0;
  logic [15:0] ulen = '0;
  logic [7:0]  itype = '0;

  function automatic bit step_flow(input logic [7:0] b, input logic last,
                                   output flow_key_t k);
    int  idx, h, cnt, need, plen;
    bit  ok;
    logic [15:0] sport, dport;
    idx = pos;
    if (idx == 0) ihl = b[3:0];
    if (idx == 2 || idx == 3) tot_len = {tot_len[7:0], b};
    if (idx == 9) proto = b;
    if (idx >= 12 && idx <= 15) saddr = {saddr[23:0], b};
    if (idx >= 16 && idx <= 19) daddr = {daddr[23:0], b};
    h = 4 * ihl;
    if (idx == h) itype = b;
    if (idx == h || idx == h + 1) port_a = {port_a[7:0], b};
    if (idx == h + 2 || idx == h + 3) port_b = {port_b[7:0], b};
    if (idx == h + 4 || idx == h + 5) ulen = {ulen[7:0], b};
    if (pos != BYTE_INDEX_MAX) pos = pos + 16'd1;
    k = '0;
    if (!last) return 1'b0;

    cnt = idx + 1;
    ok = (cnt >= int'(MIN_PACKET_BYTES));
    sport = '0;
    dport = '0;
    plen = 0;
    need = 0;
    if (proto == PROTO_TCP) begin
      need = h + 4;
      sport = port_a;
      dport = port_b;
      plen = int'(tot_len) - h - int'(TCP_HDR_BYTES);
    end else if (proto == PROTO_UDP) begin
      need = h + 6;
      sport = port_a;
      dport = port_b;
      plen = int'(ulen) - int'(UDP_HDR_BYTES);
    end else if (proto == PROTO_ICMP) begin
      need = h + 6;
      if (itype != ICMP_ECHO_REQUEST) ok = 1'b0;
      sport = ulen;
      plen = int'(tot_len) - h - int'(ICMP_HDR_BYTES);
    end else begin
      ok = 1'b0;
    end
    if (cnt < need) ok = 1'b0;
    if (plen < 0) plen = 0;
    if (ok) begin
      k.accepted = 1'b1;
      k.proto_number = proto;
      k.source_address = saddr;
      k.dest_address = daddr;
      k.source_port = sport;
      k.dest_port = dport;
      k.payload_len = plen[15:0];
    end

    pos = '0;
    ihl = '0;
    tot_len = '0;
    proto = '0;
    saddr = '0;
    daddr = '0;
    port_a = '0;
    port_b = '0;
    ulen = '0;
    itype = '0;
    return 1'b1;
  endfunction

  // mostly back-to-back, some short gaps, rare long ones
  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // fill: 0 random bytes, 1 all zeros, 2 all ones
  task automatic queue_packet(input logic [7:0] prot, input int hl, input int len,
                              input logic [7:0] ty, input logic [15:0] tl,
                              input logic [15:0] l4len, input int fill,
                              input bit drain);
    logic [7:0] pb[];
    pkt_item_t  it;
    int         h;
    h = 4 * hl;
    pb = new[len];
    for (int i = 0; i < len; i++)
      pb[i] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
    // transport fields first so the IP fields win where a short header overlaps
    if (prot == PROTO_ICMP && h < len) pb[h] = ty;
    if (h + 4 < len) pb[h + 4] = l4len[15:8];
    if (h + 5 < len) pb[h + 5] = l4len[7:0];
    if (len > 2) pb[2] = tl[15:8];
    if (len > 3) pb[3] = tl[7:0];
    if (len > 9) pb[9] = prot;
    pb[0][3:0] = hl[3:0];
    for (int i = 0; i < len; i++) begin
      it.data = pb[i];
      it.last = (i == len - 1);
      it.drain = drain && (i == 0);
      byte_q.push_back(it);
    end
  endtask

  task automatic random_packet();
    logic [7:0]  prot, ty;
    logic [15:0] tl, l4len;
    int          r, hl, h, len, fill;
    r = $urandom_range(0, 99);
    prot = (r < 35) ? PROTO_TCP : (r < 70) ? PROTO_UDP : (r < 92) ? PROTO_ICMP :
           8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    hl = (r < 75) ? 5 : (r < 92) ? $urandom_range(6, 15) : $urandom_range(0, 4);
    h = 4 * hl;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = h + 6 + $urandom_range(0, 16);
      if (len < 20) len = 20 + $urandom_range(0, 8);
    end else if (r < 80) len = $urandom_range(h + 6, h + 200);
    else if (r < 92) len = $urandom_range(1, h + 5);
    else len = $urandom_range(1, 19);
    r = $urandom_range(0, 99);
    tl = (r < 70) ? 16'(len) : (r < 85) ? 16'($urandom_range(0, 65535)) :
         16'($urandom_range(0, h + 20));
    r = $urandom_range(0, 99);
    l4len = (r < 70) ? 16'(len - h) : (r < 85) ? 16'($urandom_range(0, 65535)) :
            16'($urandom_range(0, 8));
    ty = ($urandom_range(0, 99) < 85) ? ICMP_ECHO_REQUEST : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    fill = (r < 94) ? 0 : (r < 97) ? 1 : 2;
    queue_packet(prot, hl, len, ty, tl, l4len, fill, $urandom_range(0, 24) == 0);
  endtask

  initial begin
    rst = 1'b1;
    pkt_if.valid = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last_byte = 1'b0;
    key_if.ready = 1'b0;

    // directed packets
    queue_packet(PROTO_TCP, 5, 40, 8'h00, 16'd40, 16'h0000, 0, 0);   // payload exactly zero
    queue_packet(PROTO_TCP, 5, 60, 8'h00, 16'd1500, 16'h0000, 2, 0);
    queue_packet(PROTO_UDP, 5, 28, 8'h00, 16'd28, 16'd8, 1, 0);
    queue_packet(PROTO_UDP, 5, 30, 8'h00, 16'd30, 16'd3, 0, 0);      // udp length clamps
    queue_packet(PROTO_UDP, 5, 30, 8'h00, 16'hFFFF, 16'hFFFF, 2, 0);
    queue_packet(PROTO_ICMP, 5, 28, ICMP_ECHO_REQUEST, 16'd84, 16'h1234, 0, 0);
    queue_packet(PROTO_ICMP, 5, 28, 8'h00, 16'd84, 16'h1234, 0, 0);  // echo reply refused
    queue_packet(8'd2, 5, 40, 8'h00, 16'd40, 16'h0000, 0, 0);        // unknown protocol
    queue_packet(PROTO_TCP, 5, 19, 8'h00, 16'd19, 16'h0000, 0, 0);   // one byte short
    queue_packet(PROTO_TCP, 5, 1, 8'h00, 16'd0, 16'h0000, 0, 0);
    queue_packet(PROTO_TCP, 0, 1, 8'h00, 16'd0, 16'h0000, 2, 0);
    queue_packet(PROTO_TCP, 15, 63, 8'h00, 16'd100, 16'h0000, 0, 0); // ends before ports
    queue_packet(PROTO_TCP, 15, 64, 8'h00, 16'd100, 16'h0000, 0, 0);
    queue_packet(PROTO_UDP, 15, 65, 8'h00, 16'd65, 16'd20, 0, 0);
    queue_packet(PROTO_UDP, 15, 66, 8'h00, 16'd66, 16'd20, 0, 0);
    queue_packet(PROTO_UDP, 0, 24, 8'h00, 16'd24, 16'd20, 0, 0);     // captures overlap header
    queue_packet(PROTO_ICMP, 2, 24, ICMP_ECHO_REQUEST, 16'd24, 16'h0000, 0, 0);
    queue_packet(PROTO_TCP, 4, 30, 8'h00, 16'd30, 16'h0000, 0, 0);
    queue_packet(PROTO_UDP, 5, 40, 8'h00, 16'd40, 16'd20, 0, 1);

    while (byte_q.size() < TOTAL_BYTES) random_packet();
    bytes_total = byte_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken < bytes_total || key_exp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (key_exp.size() != 0) errors++;
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // byte sender
  pkt_item_t send_item;
  flow_key_t send_key;
  int        send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      pkt_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (pkt_if.valid && pkt_if.ready) begin
        if (step_flow(pkt_if.data_byte, pkt_if.last_byte, send_key))
          key_exp.push_back(send_key);
        bytes_taken++;
      end
      if (!pkt_if.valid || pkt_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pkt_if.valid <= 1'b0;
        end else if (byte_q.size() == 0 || (byte_q[0].drain && key_exp.size() != 0)) begin
          pkt_if.valid <= 1'b0;
        end else begin
          send_item = byte_q.pop_front();
          pkt_if.valid <= 1'b1;
          pkt_if.data_byte <= send_item.data;
          pkt_if.last_byte <= send_item.last;
          send_gap = gap_len(cyc[9:7] == 3'd0);
        end
      end
    end
  end

  // key receiver and checker
  flow_key_t got_key, want_key;
  int        hold_left = 0;
  int        stall_left = 0;
  bit        long_done = 0;

  always @(posedge clk) begin
    if (rst) begin
      key_if.ready <= 1'b0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        got_key.accepted = key_if.accepted;
        got_key.proto_number = key_if.proto_number;
        got_key.source_address = key_if.source_address;
        got_key.dest_address = key_if.dest_address;
        got_key.source_port = key_if.source_port;
        got_key.dest_port = key_if.dest_port;
        got_key.payload_len = key_if.payload_len;
        keys_seen++;
        if (key_exp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("key %0d: unexpected item %p", keys_seen, got_key);
        end else begin
          want_key = key_exp.pop_front();
          if (got_key !== want_key) begin
            errors++;
            if (errors <= 10) begin
              $display("key %0d mismatch", keys_seen);
              $display("  exp acc=%b proto=%0d src=%h dst=%h sp=%0d dp=%0d len=%0d",
                       want_key.accepted, want_key.proto_number, want_key.source_address,
                       want_key.dest_address, want_key.source_port, want_key.dest_port,
                       want_key.payload_len);
              $display("  got acc=%b proto=%0d src=%h dst=%h sp=%0d dp=%0d len=%0d",
                       got_key.accepted, got_key.proto_number, got_key.source_address,
                       got_key.dest_address, got_key.source_port, got_key.dest_port,
                       got_key.payload_len);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        key_if.ready <= 1'b0;
      end else if (!long_done && keys_seen >= 25) begin
        // long back-pressure so the input side has to stall
        long_done = 1'b1;
        hold_left = LONG_HOLD;
        key_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        key_if.ready <= 1'b0;
      end else begin
        key_if.ready <= 1'b1;
        stall_left = gap_len(cyc[9:7] == 3'd3);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((pkt_if.valid && pkt_if.ready) || (key_if.valid && key_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
hdl/ipv4fk_pkg.sv
hdl/ipv4fk_byte_if.sv
hdl/ipv4fk_key_if.sv
hdl/ipv4_flow_key_extractor_core.sv
bench/tb.sv
